// ----- design/hls_pkg.sv -----
// Shared types and constants for the histogram linear stretch unit.
// No dependencies; every other design file imports this package.
package hls_pkg;

  localparam int unsigned PIXEL_BITS  = 8;
  localparam int unsigned NUM_BITS    = 2 * PIXEL_BITS;
  localparam int unsigned CNT_BITS    = $clog2(PIXEL_BITS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

  // Mode codes of an input beat
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_STRETCH = 1'b1;

  // One division job: numerator (p - min) * PIX_MAX, divisor max - min
  typedef struct packed {
    logic                  empty;
    logic [NUM_BITS-1:0]   num;
    logic [PIXEL_BITS-1:0] den;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } back_state_e;

endpackage

// ----- design/hls_front.sv -----
// Front end: takes input beats, tracks the frame min/max and builds division jobs.
// Depends on hls_pkg.
module hls_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           mode_i,
  input  logic [hls_pkg::PIXEL_BITS-1:0] pixel_i,
  input  logic                           first_i,
  output logic                           push_o,
  output hls_pkg::job_t                  job_o
);
  import hls_pkg::*;

  logic [PIXEL_BITS-1:0] min_q, min_d;
  logic [PIXEL_BITS-1:0] max_q, max_d;
  logic                  seen_q, seen_d;
  logic                  accept;
  logic [PIXEL_BITS-1:0] clamped;
  logic [PIXEL_BITS-1:0] diff;

  assign accept = in_valid_i && !in_stall_i;

  // Clamp the pixel into the measured range and form the job
  always_comb begin
    if (pixel_i < min_q) begin
      clamped = min_q;
    end else if (pixel_i > max_q) begin
      clamped = max_q;
    end else begin
      clamped = pixel_i;
    end
    diff      = clamped - min_q;
    job_o.empty = !seen_q || (max_q <= min_q);
    job_o.num   = {diff, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, diff};
    job_o.den   = max_q - min_q;
  end

  assign push_o = accept && (mode_i == MODE_STRETCH);

  // Update the running min/max on measure beats
  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    seen_d = seen_q;
    if (accept && (mode_i == MODE_MEASURE)) begin
      seen_d = 1'b1;
      if (first_i) begin
        min_d = pixel_i;
        max_d = pixel_i;
      end else begin
        if (pixel_i < min_q) min_d = pixel_i;
        if (pixel_i > max_q) max_d = pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= PIX_MAX;
      max_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ----- design/hls_queue.sv -----
// Short job queue between front and back end.
// Depends on hls_pkg.
module hls_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hls_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output hls_pkg::job_t job_o
);
  import hls_pkg::*;

  job_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/hls_back.sv -----
// Back end: restoring divider, one quotient bit per cycle, and output register.
// Depends on hls_pkg.
module hls_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  hls_pkg::job_t                  job_i,
  output logic                           job_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hls_pkg::PIXEL_BITS-1:0] stretched_o
);
  import hls_pkg::*;

  back_state_e           state_q, state_d;
  logic [PIXEL_BITS-1:0] rem_q, rem_d;
  logic [PIXEL_BITS-1:0] lo_q, lo_d;
  logic [PIXEL_BITS-1:0] den_q, den_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [PIXEL_BITS-1:0] out_data_q, out_data_d;
  logic                  out_free;
  logic [PIXEL_BITS:0]   shifted;
  logic [PIXEL_BITS:0]   trial;
  logic                  qbit;

  assign out_free = !out_valid_q || !out_stall_i;

  // One restoring step: shift in the next numerator bit, try to subtract
  always_comb begin
    shifted = {rem_q, lo_q[PIXEL_BITS-1]};
    trial   = shifted - {1'b0, den_q};
    qbit    = (shifted >= {1'b0, den_q});
  end

  // Sequence pop, divide and hand-off
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    job_pop_o   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.empty) begin
            lo_d    = '0;
            state_d = S_HOLD;
          end else begin
            // the high half is already below the divisor, so only the low bits remain
            rem_d   = job_i.num[NUM_BITS-1:PIXEL_BITS];
            lo_d    = job_i.num[PIXEL_BITS-1:0];
            den_d   = job_i.den;
            cnt_d   = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = qbit ? trial[PIXEL_BITS-1:0] : shifted[PIXEL_BITS-1:0];
        lo_d  = (lo_q << 1) | {{(PIXEL_BITS-1){1'b0}}, qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(PIXEL_BITS - 1)) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = lo_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    lo_q       <= lo_d;
    den_q      <= den_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign stretched_o = out_data_q;

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CNT_BITS'(PIXEL_BITS)))
    else $error("divider step count out of range");

  a_load_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded from hold state");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q == S_DIV || state_q == S_HOLD))
    else $error("pop did not start a job");
`endif

endmodule

// ----- design/histogram_linear_stretch_unit.sv -----
// Top level of the histogram linear stretch unit.
// Depends on hls_pkg, hls_front, hls_queue and hls_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode_i, pixel_i, first_i.
//   A measure beat (mode 0) updates the frame min/max in the cycle it is
//   taken and gives no result; first_i restarts min and max at that pixel.
//   A stretch beat (mode 1) gives one stretched_o value on the output
//   channel (out_valid_o / out_stall_i), in input order.
//   Measure beats are taken at one per cycle while the job queue has room.
//   A stretch beat is turned into a division job in the front end and queued
//   (two entries). The back end divides with a restoring divider, one
//   quotient bit per cycle: it pops the job, runs PIXEL_BITS steps and then
//   loads the output register.
//   If nothing has been measured or max equals min, the result is 0 and the
//   divider is skipped.
//   When the receiver stalls, the result holds in the output register, the
//   back end waits, and the queue fills until in_stall_o rises.
//   Reset sets min to full scale, max to 0, and empties queue and output.
module histogram_linear_stretch_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [hls_pkg::PIXEL_BITS-1:0] pixel_i,
  input  logic                           first_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hls_pkg::PIXEL_BITS-1:0] stretched_o
);
  import hls_pkg::*;

  logic push;
  logic full;
  logic job_valid;
  logic job_pop;
  job_t job_in;
  job_t job_out;

  assign in_stall_o = full;

  hls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .mode_i     (mode_i),
    .pixel_i    (pixel_i),
    .first_i    (first_i),
    .push_o     (push),
    .job_o      (job_in)
  );

  hls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .job_o   (job_out)
  );

  hls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stretched_o (stretched_o)
  );

endmodule
